// ----- src/decimating_window_buffer_quantizer_macros.svh -----
// assertion helpers for the buffer rtl file
`ifndef DECIMATING_WINDOW_BUFFER_QUANTIZER_MACROS_SVH
`define DECIMATING_WINDOW_BUFFER_QUANTIZER_MACROS_SVH

// property checked at every clock edge outside reset
`define DWBQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next cycle
`define DWBQ_ASSERT_NEXT(label, cond, expect_next, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> (expect_next)) else $error(msg);

`endif

// ----- src/dwbq_pkg.sv -----
`default_nettype none

package dwbq_pkg;

    // geometry defaults
    localparam int RING_DEPTH_DEFAULT   = 600;
    localparam int INITIAL_FILL_DEFAULT = 200;

    // stored word and quantizer arithmetic
    localparam int WORD_W      = 20;
    localparam int SCALE_W     = 24;
    localparam int SCALE_SHIFT = 28;

    typedef logic signed [WORD_W-1:0] word_t;

    // command codes
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_CLEAR  = 2'd1;
    localparam logic [1:0] CMD_POLL   = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_DECIMATION = 2'd0;
    localparam logic [1:0] CFG_WINDOW_LEN = 2'd1;
    localparam logic [1:0] CFG_INV_SCALE  = 2'd2;
    localparam logic [1:0] CFG_ZERO_POINT = 2'd3;

    // reset values
    localparam logic [7:0]         DECIMATION_RESET = 8'd1;
    localparam logic [9:0]         WINDOW_LEN_RESET = 10'd384;
    localparam logic [SCALE_W-1:0] INV_SCALE_RESET  = 24'd65536;
    localparam logic signed [7:0]  ZERO_POINT_RESET = 8'sd0;
    localparam logic [7:0]         SKIP_RESET       = 8'd1;

    // sample times ten as shift and add
    function automatic word_t times_ten(input logic signed [15:0] a);
        word_t ext;
        begin
            ext = WORD_W'(a);
            return (ext <<< 3) + (ext <<< 1);
        end
    endfunction

endpackage

`default_nettype wire

// ----- src/decimating_window_buffer_quantizer.sv -----
// Decimating window buffer with int8 quantizer.
// Requests arrive on in_valid/in_ready with cmd and its operands; each request
// gives exactly one result on out_valid/out_ready (sample_kept, window_ready,
// quantized_value, the fields not used by the command are zero).
// Configuration registers are written through cfg_write_en/cfg_index/cfg_data,
// by the user only while no request is in flight; the block does not enforce it.
// Requests are handled one at a time by a small sequencer around a single-port
// ring memory with a registered read. From acceptance to the next acceptance,
// poll, clear and a skipped sample pass only through the result state; a kept
// sample makes three word writes through the one memory port; a read steps
// through index reduction, address, memory read, multiply, round and saturate.
// The result is held in an output register: the next request is taken while a
// result waits, and the sequencer holds its next result until the receiver
// takes the previous one, so a stalled receiver stalls the input after one.
// Reset clears positions, counters and flags at once with no sweep; ring words
// not written since reset or the last clear read as zero through a fill mark
// (write position plus a wrapped flag), so clear needs no sweep either.
`default_nettype none

`include "decimating_window_buffer_quantizer_macros.svh"

module decimating_window_buffer_quantizer #(
    parameter int RING_DEPTH   = dwbq_pkg::RING_DEPTH_DEFAULT,
    parameter int INITIAL_FILL = dwbq_pkg::INITIAL_FILL_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // configuration port
    input  wire logic                             cfg_write_en,
    input  wire logic [1:0]                       cfg_index,
    input  wire logic [dwbq_pkg::SCALE_W-1:0]     cfg_data,
    // request channel
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [1:0]                       cmd,
    input  wire logic signed [15:0]               accel_x,
    input  wire logic signed [15:0]               accel_y,
    input  wire logic signed [15:0]               accel_z,
    input  wire logic [9:0]                       read_index,
    // result channel
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  sample_kept,
    output logic                                  window_ready,
    output logic signed [7:0]                     quantized_value
);

    localparam int POS_W   = $clog2(RING_DEPTH);
    localparam int MOD_SH  = 24;
    localparam logic [MOD_SH:0] MOD_RECIP =
        (MOD_SH+1)'(((1 << MOD_SH) + RING_DEPTH - 1) / RING_DEPTH);
    localparam int PROD_W  = dwbq_pkg::WORD_W + dwbq_pkg::SCALE_W + 1;
    localparam int QUO_W   = PROD_W + 1 - dwbq_pkg::SCALE_SHIFT;

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WRITE = 3'd1;
    localparam logic [2:0] ST_MOD   = 3'd2;
    localparam logic [2:0] ST_ADDR  = 3'd3;
    localparam logic [2:0] ST_DATA  = 3'd4;
    localparam logic [2:0] ST_QUANT = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    // reduce a 10-bit value modulo the ring depth by reciprocal multiply
    function automatic logic [POS_W-1:0] mod_depth(input logic [9:0] x);
        logic [MOD_SH+10:0] prod;
        logic [10:0]        quo;
        logic [22:0]        back;
        logic [22:0]        rem;
        begin
            prod = (MOD_SH+11)'(x) * (MOD_SH+11)'(MOD_RECIP);
            quo  = prod[MOD_SH+10:MOD_SH];
            back = 23'(quo) * 23'(RING_DEPTH);
            rem  = 23'(x) - back;
            return rem[POS_W-1:0];
        end
    endfunction

    // configuration registers
    logic [7:0]                   decimation_reg;
    logic [9:0]                   window_len_reg;
    logic [dwbq_pkg::SCALE_W-1:0] inv_scale_reg;
    logic signed [7:0]            zero_point_reg;

    // control state
    logic [2:0]       state_reg, state_next;
    logic [1:0]       word_cnt_reg, word_cnt_next;
    logic [POS_W-1:0] write_pos_reg, write_pos_next;
    logic             wrapped_reg, wrapped_next;
    logic             awaiting_reg, awaiting_next;
    logic             fresh_reg, fresh_next;
    logic [7:0]       skip_reg, skip_next;
    logic             out_valid_reg, out_valid_next;

    // payload registers
    logic signed [15:0]       ax_reg, ay_reg, az_reg;
    logic [9:0]               ri_reg;
    logic [POS_W-1:0]         ri_mod_reg, wl_mod_reg;
    logic                     hit_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     res_kept_reg, res_kept_next;
    logic                     res_ready_reg, res_ready_next;
    logic signed [7:0]        res_quant_reg, res_quant_next;
    logic                     sample_kept_reg, window_ready_reg;
    logic signed [7:0]        quant_reg;

    // memory port
    logic                  mem_we;
    logic [POS_W-1:0]      mem_addr;
    dwbq_pkg::word_t       mem_wdata;
    dwbq_pkg::word_t       mem_q;
    dwbq_pkg::word_t       mem [RING_DEPTH];

    // read address path
    logic [POS_W:0]   sum_ab;
    logic [POS_W-1:0] wrap_ab;
    logic [POS_W-1:0] read_addr;
    logic [POS_W:0]   under_sum;

    // quantizer path
    dwbq_pkg::word_t          word_sel;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W:0]   biased;
    logic signed [QUO_W-1:0]  quo_floor;
    logic signed [QUO_W-1:0]  quo_trunc;

    logic accept;
    logic out_free;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);

    assign out_valid       = out_valid_reg;
    assign sample_kept     = sample_kept_reg;
    assign window_ready    = window_ready_reg;
    assign quantized_value = quant_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decimation_reg <= dwbq_pkg::DECIMATION_RESET;
            window_len_reg <= dwbq_pkg::WINDOW_LEN_RESET;
            inv_scale_reg  <= dwbq_pkg::INV_SCALE_RESET;
            zero_point_reg <= dwbq_pkg::ZERO_POINT_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                dwbq_pkg::CFG_DECIMATION: decimation_reg <= cfg_data[7:0];
                dwbq_pkg::CFG_WINDOW_LEN: window_len_reg <= cfg_data[9:0];
                dwbq_pkg::CFG_INV_SCALE:  inv_scale_reg  <= cfg_data;
                dwbq_pkg::CFG_ZERO_POINT: zero_point_reg <= cfg_data[7:0];
                default:                  decimation_reg <= decimation_reg;
            endcase
        end
    end

    // window element address: write position plus index minus length, mod depth
    always_comb
    begin
        sum_ab = {1'b0, write_pos_reg} + {1'b0, ri_mod_reg};
        if (sum_ab >= (POS_W+1)'(RING_DEPTH))
        begin
            sum_ab = sum_ab - (POS_W+1)'(RING_DEPTH);
        end
        wrap_ab   = sum_ab[POS_W-1:0];
        under_sum = {1'b0, wrap_ab} + (POS_W+1)'(RING_DEPTH) - {1'b0, wl_mod_reg};
        if (wrap_ab >= wl_mod_reg)
        begin
            read_addr = wrap_ab - wl_mod_reg;
        end
        else
        begin
            read_addr = under_sum[POS_W-1:0];
        end
    end

    // scale by the reciprocal, add zero point, truncate toward zero, saturate
    always_comb
    begin
        word_sel  = hit_reg ? mem_q : '0;
        prod_next = PROD_W'(word_sel) * $signed({1'b0, inv_scale_reg});
        biased    = (PROD_W+1)'(prod_reg)
                  + ((PROD_W+1)'(zero_point_reg) <<< dwbq_pkg::SCALE_SHIFT);
        quo_floor = biased[PROD_W:dwbq_pkg::SCALE_SHIFT];
        if (biased[PROD_W] && (biased[dwbq_pkg::SCALE_SHIFT-1:0] != '0))
        begin
            quo_trunc = quo_floor + QUO_W'(1);
        end
        else
        begin
            quo_trunc = quo_floor;
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        word_cnt_next  = word_cnt_reg;
        write_pos_next = write_pos_reg;
        wrapped_next   = wrapped_reg;
        awaiting_next  = awaiting_reg;
        fresh_next     = fresh_reg;
        skip_next      = skip_reg;
        out_valid_next = out_valid_reg;
        res_kept_next  = res_kept_reg;
        res_ready_next = res_ready_reg;
        res_quant_next = res_quant_reg;
        mem_we         = 1'b0;
        mem_addr       = write_pos_reg;
        mem_wdata      = dwbq_pkg::times_ten(ay_reg);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_kept_next  = 1'b0;
                    res_ready_next = 1'b0;
                    res_quant_next = '0;
                    state_next     = ST_DONE;
                    unique case (cmd)
                        dwbq_pkg::CMD_SAMPLE:
                        begin
                            if (skip_reg != decimation_reg)
                            begin
                                skip_next = skip_reg + 8'd1;
                            end
                            else
                            begin
                                skip_next     = dwbq_pkg::SKIP_RESET;
                                fresh_next    = 1'b1;
                                res_kept_next = 1'b1;
                                word_cnt_next = '0;
                                state_next    = ST_WRITE;
                            end
                        end
                        dwbq_pkg::CMD_CLEAR:
                        begin
                            write_pos_next = '0;
                            wrapped_next   = 1'b0;
                            awaiting_next  = 1'b1;
                            fresh_next     = 1'b0;
                        end
                        dwbq_pkg::CMD_POLL:
                        begin
                            if (fresh_reg)
                            begin
                                fresh_next = 1'b0;
                                if (32'(write_pos_reg) >= 32'(INITIAL_FILL))
                                begin
                                    awaiting_next = 1'b0;
                                end
                                res_ready_next = !awaiting_next;
                            end
                        end
                        dwbq_pkg::CMD_READ:
                        begin
                            state_next = ST_MOD;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_WRITE:
            begin
                // y, x, z at successive ring positions
                mem_we = 1'b1;
                case (word_cnt_reg)
                    2'd0:    mem_wdata = dwbq_pkg::times_ten(ay_reg);
                    2'd1:    mem_wdata = dwbq_pkg::times_ten(ax_reg);
                    default: mem_wdata = dwbq_pkg::times_ten(az_reg);
                endcase
                if (write_pos_reg == POS_W'(RING_DEPTH - 1))
                begin
                    write_pos_next = '0;
                    wrapped_next   = 1'b1;
                end
                else
                begin
                    write_pos_next = write_pos_reg + POS_W'(1);
                end
                word_cnt_next = word_cnt_reg + 2'd1;
                if (word_cnt_reg == 2'd2)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_MOD:
            begin
                state_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                mem_addr   = read_addr;
                state_next = ST_DATA;
            end
            ST_DATA:
            begin
                state_next = ST_QUANT;
            end
            ST_QUANT:
            begin
                if (quo_trunc > QUO_W'(127))
                begin
                    res_quant_next = 8'sd127;
                end
                else if (quo_trunc < -QUO_W'(128))
                begin
                    res_quant_next = -8'sd128;
                end
                else
                begin
                    res_quant_next = quo_trunc[7:0];
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            word_cnt_reg  <= '0;
            write_pos_reg <= '0;
            wrapped_reg   <= 1'b0;
            awaiting_reg  <= 1'b1;
            fresh_reg     <= 1'b0;
            skip_reg      <= dwbq_pkg::SKIP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            word_cnt_reg  <= word_cnt_next;
            write_pos_reg <= write_pos_next;
            wrapped_reg   <= wrapped_next;
            awaiting_reg  <= awaiting_next;
            fresh_reg     <= fresh_next;
            skip_reg      <= skip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ax_reg <= accel_x;
            ay_reg <= accel_y;
            az_reg <= accel_z;
            ri_reg <= read_index;
        end
        if (state_reg == ST_MOD)
        begin
            ri_mod_reg <= mod_depth(ri_reg);
            wl_mod_reg <= mod_depth(window_len_reg);
        end
        if (state_reg == ST_ADDR)
        begin
            hit_reg <= wrapped_reg || (read_addr < write_pos_reg);
        end
        if (state_reg == ST_DATA)
        begin
            prod_reg <= prod_next;
        end
        res_kept_reg  <= res_kept_next;
        res_ready_reg <= res_ready_next;
        res_quant_reg <= res_quant_next;
        if ((state_reg == ST_DONE) && out_free)
        begin
            sample_kept_reg  <= res_kept_reg;
            window_ready_reg <= res_ready_reg;
            quant_reg        <= res_quant_reg;
        end
    end

    // sample ring, single port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        mem_q <= mem[mem_addr];
    end

    // checks
    `DWBQ_ASSERT_NEXT(a_one_request_at_a_time, accept, !in_ready, "request taken while busy")
    `DWBQ_ASSERT(a_write_pos_in_ring, 32'(write_pos_reg) < 32'(RING_DEPTH), "write position past ring")
    `DWBQ_ASSERT_NEXT(a_clear_resets_fill, accept && (cmd == dwbq_pkg::CMD_CLEAR), (write_pos_reg == '0) && !wrapped_reg && awaiting_reg && !fresh_reg, "clear did not reset fill")
    `DWBQ_ASSERT(a_single_result_field, !out_valid || ($countones({sample_kept, window_ready, quantized_value != 8'sd0}) <= 1), "more than one result field set")
    `DWBQ_ASSERT(a_mem_write_only_in_write, !mem_we || (state_reg == ST_WRITE), "ring written outside sample store")

endmodule

`default_nettype wire
